// ===== hdl/health_scored_round_robin_selector_top_macros.svh =====
// assertion macros for the health scored selector
`ifndef HEALTH_SCORED_ROUND_ROBIN_SELECTOR_TOP_MACROS_SVH
`define HEALTH_SCORED_ROUND_ROBIN_SELECTOR_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define HSRR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define HSRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hsrr_pkg.sv =====
// shared types, codes and constants of the health scored selector
package hsrr_pkg;

    localparam int MAX_ENTRIES_DEF = 8;

    localparam int HEALTH_W   = 17;
    localparam int FACTOR_W   = 16;
    localparam int FAIL_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [HEALTH_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [FAIL_W-1:0]   FAIL_MAX = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 2'd3;

    localparam logic [FACTOR_W-1:0] DECAY_RST      = 16'd58982;
    localparam logic [FACTOR_W-1:0] PENALTY_RST    = 16'd19661;
    localparam logic [HEALTH_W-1:0] FLOOR_RST      = 17'd6554;
    localparam logic [FAIL_W-1:0]   FAIL_LIMIT_RST = 8'd3;

    // item kinds
    localparam logic [2:0] KIND_SELECT  = 3'd0;
    localparam logic [2:0] KIND_SUCCESS = 3'd1;
    localparam logic [2:0] KIND_FAILURE = 3'd2;
    localparam logic [2:0] KIND_ADD     = 3'd3;
    localparam logic [2:0] KIND_REMOVE  = 3'd4;

    // error classes with their own handling
    localparam logic [2:0] ERR_RATE_LIMIT = 3'd3;
    localparam logic [2:0] ERR_AUTH       = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] err_class;
        logic [2:0] entry_index;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [2:0]          chosen_index;
        logic [HEALTH_W-1:0] chosen_health;
        logic                used_fallback;
        logic [3:0]          entry_count;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic [HEALTH_W-1:0] health;
        logic [FAIL_W-1:0]   fail_run;
    } entry_t;

    function automatic rsp_t make_rsp(
        input logic [1:0]          status,
        input logic [2:0]          idx,
        input logic [HEALTH_W-1:0] health,
        input logic                fallback,
        input logic [3:0]          cnt
    );
        rsp_t r;
        r.status        = status;
        r.chosen_index  = idx;
        r.chosen_health = health;
        r.used_fallback = fallback;
        r.entry_count   = cnt;
        return r;
    endfunction

endpackage

// ===== hdl/hsrr_health_calc.sv =====
// health update datapath: registered multiply, then round, shift and cap
module hsrr_health_calc
    import hsrr_pkg::*;
(
    input  logic                clk,
    input  logic                success,
    input  logic [HEALTH_W-1:0] health,
    input  logic [FACTOR_W-1:0] decay,
    input  logic [FACTOR_W-1:0] penalty,
    output logic [HEALTH_W-1:0] health_new
);

    logic [HEALTH_W-1:0]     factor;
    logic [HEALTH_W-1:0]     keep_q;
    logic [2*HEALTH_W-1:0]   prod_next;
    logic [2*HEALTH_W-1:0]   prod_reg;
    logic [2*HEALTH_W:0]     bias;
    logic [2*HEALTH_W:0]     sum;
    logic [HEALTH_W+1:0]     scaled;

    assign factor    = success ? {1'b0, decay} : (ONE_Q16 - {1'b0, penalty});
    assign prod_next = (2*HEALTH_W)'(health) * (2*HEALTH_W)'(factor);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // success pulls toward 1.0 with weight (1 - decay)
    assign keep_q = ONE_Q16 - {1'b0, decay};
    assign bias   = success ? ({2'b00, keep_q, 16'h0000} + 35'd32768) : 35'd32768;
    assign sum    = {1'b0, prod_reg} + bias;
    assign scaled = sum[2*HEALTH_W:16];

    assign health_new = (scaled > (HEALTH_W+2)'(ONE_Q16)) ? ONE_Q16 : scaled[HEALTH_W-1:0];

endmodule

// ===== hdl/health_scored_round_robin_selector_top.sv =====
// health scored round-robin selector: entry table in one synchronous ram, sequenced ops
// one item at a time; result in the output register, next item taken as the fsm idles
// select: scans from the cursor until an entry above the floor is hit, else falls back to the healthiest
// success/failure: read, multiply, write back, result; add and unused kinds: straight to the result
// remove: each later entry is read and written one place down, then the last slot is cleared
// async active-low reset clears table count and cursor, loads config defaults; ram contents are not cleared
`include "health_scored_round_robin_selector_top_macros.svh"

module health_scored_round_robin_selector_top
    import hsrr_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = CNT_W + 3;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SEL     = 4'd1;
    localparam logic [3:0] ST_FB      = 4'd2;
    localparam logic [3:0] ST_UPD_MUL = 4'd3;
    localparam logic [3:0] ST_UPD_WB  = 4'd4;
    localparam logic [3:0] ST_RM_RD   = 4'd5;
    localparam logic [3:0] ST_RM_WR   = 4'd6;
    localparam logic [3:0] ST_RM_END  = 4'd7;
    localparam logic [3:0] ST_RESP    = 4'd8;

    function automatic logic [IDX_W-1:0] wrap_inc(
        input logic [IDX_W-1:0] i,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W-1:0] s;
        s = CNT_W'(i) + CNT_W'(1);
        return (s == n) ? '0 : IDX_W'(s);
    endfunction

    // entry table
    entry_t              mem [MAX_ENTRIES];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    entry_t              mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    // control state
    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cursor_reg, cursor_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [FACTOR_W-1:0] decay_reg;
    logic [FACTOR_W-1:0] penalty_reg;
    logic [HEALTH_W-1:0] floor_reg;
    logic [FAIL_W-1:0]   limit_reg;

    // working registers
    req_t                op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0]    chk_reg, chk_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [HEALTH_W-1:0] best_h_reg, best_h_next;
    entry_t              ent_reg, ent_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;

    logic [IDX_W-1:0]    cur_eff;
    logic [IDX_W-1:0]    last_sel;
    logic [HEALTH_W-1:0] health_new;
    logic [FAIL_W-1:0]   fail_inc;
    logic                sel_hit;
    logic                sel_better;
    logic [CNT_W-1:0]    count_dec;

    assign cur_eff   = (CNT_W'(cursor_reg) < count_reg) ? cursor_reg : '0;
    assign last_sel  = (cur_eff == '0) ? IDX_W'(count_reg - CNT_W'(1)) : cur_eff - IDX_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    assign sel_hit    = mem_rdata.valid && (mem_rdata.health > floor_reg);
    assign sel_better = (mem_rdata.health > best_h_reg) ||
                        ((mem_rdata.health == best_h_reg) && (idx_reg < best_idx_reg));
    assign fail_inc   = (ent_reg.fail_run == FAIL_MAX) ? FAIL_MAX : ent_reg.fail_run + 8'd1;

    hsrr_health_calc u_calc (
        .clk        (clk),
        .success    (op_reg.kind == KIND_SUCCESS),
        .health     (mem_rdata.health),
        .decay      (decay_reg),
        .penalty    (penalty_reg),
        .health_new (health_new)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        scan_addr_next = scan_addr_reg;
        chk_next       = chk_reg;
        best_idx_next  = best_idx_reg;
        best_h_next    = best_h_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = req;
                    unique case (req.kind) inside
                        KIND_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = make_rsp(STATUS_EMPTY, 3'd0, '0, 1'b0, 4'(count_reg));
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                mem_raddr      = cur_eff;
                                idx_next       = cur_eff;
                                scan_addr_next = wrap_inc(cur_eff, count_reg);
                                chk_next       = '0;
                                best_idx_next  = '0;
                                best_h_next    = '0;
                                state_next     = ST_SEL;
                            end
                        end
                        KIND_SUCCESS, KIND_FAILURE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = make_rsp(STATUS_EMPTY, 3'd0, '0, 1'b0, 4'(count_reg));
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                mem_raddr  = last_sel;
                                idx_next   = last_sel;
                                state_next = ST_UPD_MUL;
                            end
                        end
                        KIND_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                res_next = make_rsp(STATUS_FULL, 3'd0, '0, 1'b0, 4'(count_reg));
                            end
                            else
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = IDX_W'(count_reg);
                                mem_wdata.valid    = 1'b1;
                                mem_wdata.health   = ONE_Q16;
                                mem_wdata.fail_run = '0;
                                count_next         = count_reg + CNT_W'(1);
                                res_next = make_rsp(STATUS_OK, 3'(count_reg), ONE_Q16, 1'b0,
                                                    4'(count_next));
                            end
                            state_next = ST_RESP;
                        end
                        KIND_REMOVE:
                        begin
                            if (CMP_W'(req.entry_index) >= CMP_W'(count_reg))
                            begin
                                res_next = make_rsp(STATUS_RANGE, req.entry_index, '0, 1'b0,
                                                    4'(count_reg));
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                idx_next   = IDX_W'(req.entry_index);
                                state_next = ST_RM_RD;
                            end
                        end
                        default:
                        begin
                            res_next   = make_rsp(STATUS_OK, 3'd0, '0, 1'b0, 4'(count_reg));
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SEL:
            begin
                // idx_reg names the entry whose data arrives this cycle
                mem_raddr      = scan_addr_reg;
                idx_next       = scan_addr_reg;
                scan_addr_next = wrap_inc(scan_addr_reg, count_reg);
                chk_next       = chk_reg + CNT_W'(1);
                if (sel_better)
                begin
                    best_idx_next = idx_reg;
                    best_h_next   = mem_rdata.health;
                end
                if (sel_hit)
                begin
                    cursor_next = wrap_inc(idx_reg, count_reg);
                    res_next    = make_rsp(STATUS_OK, 3'(idx_reg), mem_rdata.health, 1'b0,
                                           4'(count_reg));
                    state_next  = ST_RESP;
                end
                else if (chk_next == count_reg)
                begin
                    state_next = ST_FB;
                end
            end
            ST_FB:
            begin
                // nothing above the floor: revive the healthiest entry
                mem_we             = 1'b1;
                mem_waddr          = best_idx_reg;
                mem_wdata.valid    = 1'b1;
                mem_wdata.health   = best_h_reg;
                mem_wdata.fail_run = '0;
                cursor_next        = wrap_inc(best_idx_reg, count_reg);
                res_next   = make_rsp(STATUS_OK, 3'(best_idx_reg), best_h_reg, 1'b1,
                                      4'(count_reg));
                state_next = ST_RESP;
            end
            ST_UPD_MUL:
            begin
                ent_next   = mem_rdata;
                state_next = ST_UPD_WB;
            end
            ST_UPD_WB:
            begin
                mem_we           = 1'b1;
                mem_waddr        = idx_reg;
                mem_wdata.health = health_new;
                if (op_reg.kind == KIND_SUCCESS)
                begin
                    mem_wdata.valid    = ent_reg.valid;
                    mem_wdata.fail_run = '0;
                end
                else
                begin
                    mem_wdata.fail_run = fail_inc;
                    mem_wdata.valid    = ent_reg.valid && (fail_inc < limit_reg) &&
                                         (op_reg.err_class != ERR_AUTH);
                    if (op_reg.err_class == ERR_RATE_LIMIT)
                    begin
                        cursor_next = wrap_inc(idx_reg, count_reg);
                    end
                end
                res_next   = make_rsp(STATUS_OK, 3'(idx_reg), health_new, 1'b0, 4'(count_reg));
                state_next = ST_RESP;
            end
            ST_RM_RD:
            begin
                // close the gap one entry at a time
                if ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg)
                begin
                    mem_raddr  = idx_reg + IDX_W'(1);
                    state_next = ST_RM_WR;
                end
                else
                begin
                    state_next = ST_RM_END;
                end
            end
            ST_RM_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_RM_RD;
            end
            ST_RM_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(count_dec);
                mem_wdata  = '0;
                count_next = count_dec;
                if (CNT_W'(cursor_reg) >= count_dec)
                begin
                    cursor_next = '0;
                end
                res_next   = make_rsp(STATUS_OK, op_reg.entry_index, '0, 1'b0, 4'(count_dec));
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            decay_reg     <= DECAY_RST;
            penalty_reg   <= PENALTY_RST;
            floor_reg     <= FLOOR_RST;
            limit_reg     <= FAIL_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DECAY:      decay_reg   <= cfg_data[FACTOR_W-1:0];
                    REG_PENALTY:    penalty_reg <= cfg_data[FACTOR_W-1:0];
                    REG_FLOOR:      floor_reg   <= cfg_data[HEALTH_W-1:0];
                    REG_FAIL_LIMIT: limit_reg   <= cfg_data[FAIL_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        scan_addr_reg <= scan_addr_next;
        chk_reg       <= chk_next;
        best_idx_reg  <= best_idx_next;
        best_h_reg    <= best_h_next;
        ent_reg       <= ent_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    logic cursor_ok;
    logic resp_load;
    logic resp_loaded;

    assign cursor_ok   = ((count_reg == '0) && (cursor_reg == '0)) ||
                         (CNT_W'(cursor_reg) < count_reg);
    assign resp_load   = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp_ready);
    assign resp_loaded = rsp_valid_reg && (state_reg == ST_IDLE);

    `HSRR_ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(MAX_ENTRIES), "count past depth")
    `HSRR_ASSERT_HOLDS(a_cursor_range, cursor_ok, "cursor outside table")
    `HSRR_ASSERT_NEXT(a_resp_drains, resp_load, resp_loaded, "result not loaded")

endmodule
